// ----- rtl/core/oled_page_framebuffer_flusher_unit_macros.svh -----
// Assertion macros shared by the framebuffer flusher RTL.
// Needs a clock named clk_i and an active-low reset named rst_ni in scope.
`ifndef OLED_PAGE_FRAMEBUFFER_FLUSHER_UNIT_MACROS_SVH
`define OLED_PAGE_FRAMEBUFFER_FLUSHER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define OPFF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define OPFF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define OPFF_ASSERT(lbl, prop, msg)
`define OPFF_ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

// ----- rtl/core/opff_pkg.sv -----
// Types, constants and the microcode ROM of the framebuffer flusher.
// No dependencies.
package opff_pkg;

  localparam int DEF_PAGE_COUNT   = 8;
  localparam int DEF_COLUMN_COUNT = 128;

  localparam logic [7:0] CONTRAST_RESET = 8'd159;

  // Link protocol bytes
  localparam logic [7:0] CMD_PREFIX     = 8'h00;
  localparam logic [7:0] DATA_PREFIX    = 8'h40;
  localparam logic [7:0] PAGE_ADDR_BASE = 8'hB0;
  localparam logic [7:0] COL_LOW_CMD    = 8'h00;
  localparam logic [7:0] COL_HIGH_CMD   = 8'h10;

  localparam int         INIT_LEN           = 25;
  localparam logic [4:0] INIT_MUX_SLOT      = 5'd4;
  localparam logic [4:0] INIT_CONTRAST_SLOT = 5'd17;

  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_FILL  = 3'd1,
    OP_CLEAR = 3'd2,
    OP_INIT  = 3'd3,
    OP_PULL  = 3'd4,
    OP_FAIL  = 3'd5
  } op_e;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_INIT = 5'b00010,
    PH_CMDS = 5'b00100,
    PH_HEAD = 5'b01000,
    PH_DATA = 5'b10000
  } phase_e;

  // Datapath action of one microcode step
  typedef enum logic [3:0] {
    A_NONE   = 4'd0,
    A_DECODE = 4'd1,
    A_WRITE  = 4'd2,
    A_FILL   = 4'd3,
    A_CLEAR  = 4'd4,
    A_INIT   = 4'd5,
    A_FAIL   = 4'd6,
    A_READ   = 4'd7,
    A_PULL   = 4'd8,
    A_EMIT   = 4'd9
  } act_e;

  // Jump condition of one microcode step
  typedef enum logic [2:0] {
    C_ALWAYS    = 3'd0,
    C_ACCEPT    = 3'd1,
    C_DISPATCH  = 3'd2,
    C_COL_END   = 3'd3,
    C_ALL_END   = 3'd4,
    C_INIT_DONE = 3'd5,
    C_OUT_FREE  = 3'd6
  } cond_e;

  typedef logic [3:0] upc_t;

  localparam upc_t U_FETCH  = 4'd0;
  localparam upc_t U_DECODE = 4'd1;
  localparam upc_t U_WRITE  = 4'd2;
  localparam upc_t U_FILL   = 4'd3;
  localparam upc_t U_CLEAR  = 4'd4;
  localparam upc_t U_INIT   = 4'd5;
  localparam upc_t U_FAIL   = 4'd6;
  localparam upc_t U_PULL   = 4'd7;
  localparam upc_t U_SEND   = 4'd8;
  localparam upc_t U_EMIT   = 4'd9;

  typedef struct packed {
    logic  in_rdy;
    act_e  act;
    cond_e cond;
    upc_t  tgt_t;
    upc_t  tgt_f;
  } uctl_t;

  function automatic uctl_t ucode(upc_t pc);
    uctl_t w;
    w = '{in_rdy: 1'b0, act: A_NONE, cond: C_ALWAYS, tgt_t: U_FETCH, tgt_f: U_FETCH};
    case (pc)
      U_FETCH:  w = '{1'b1, A_NONE,   C_ACCEPT,    U_DECODE, U_FETCH};
      U_DECODE: w = '{1'b0, A_DECODE, C_DISPATCH,  U_EMIT,   U_EMIT};
      U_WRITE:  w = '{1'b0, A_WRITE,  C_ALWAYS,    U_EMIT,   U_EMIT};
      U_FILL:   w = '{1'b0, A_FILL,   C_COL_END,   U_EMIT,   U_FILL};
      U_CLEAR:  w = '{1'b0, A_CLEAR,  C_ALL_END,   U_EMIT,   U_CLEAR};
      U_INIT:   w = '{1'b0, A_INIT,   C_ALWAYS,    U_EMIT,   U_EMIT};
      U_FAIL:   w = '{1'b0, A_FAIL,   C_ALWAYS,    U_EMIT,   U_EMIT};
      U_PULL:   w = '{1'b0, A_READ,   C_ALWAYS,    U_SEND,   U_SEND};
      U_SEND:   w = '{1'b0, A_PULL,   C_INIT_DONE, U_CLEAR,  U_EMIT};
      U_EMIT:   w = '{1'b0, A_EMIT,   C_OUT_FREE,  U_FETCH,  U_EMIT};
      default:  w = '{1'b1, A_NONE,   C_ACCEPT,    U_DECODE, U_FETCH};
    endcase
    return w;
  endfunction

  // Panel power-up command list; mux ratio and contrast slots are patched in the datapath
  function automatic logic [7:0] init_byte(logic [4:0] idx);
    logic [7:0] b;
    case (idx)
      5'd0:    b = 8'hAE;
      5'd1:    b = 8'hD5;
      5'd2:    b = 8'h80;
      5'd3:    b = 8'hA8;
      5'd4:    b = 8'h3F;
      5'd5:    b = 8'hD3;
      5'd6:    b = 8'h00;
      5'd7:    b = 8'h40;
      5'd8:    b = 8'h8D;
      5'd9:    b = 8'h14;
      5'd10:   b = 8'h20;
      5'd11:   b = 8'h02;
      5'd12:   b = 8'hA1;
      5'd13:   b = 8'hC8;
      5'd14:   b = 8'hDA;
      5'd15:   b = 8'h12;
      5'd16:   b = 8'h81;
      5'd17:   b = 8'h9F;
      5'd18:   b = 8'hD9;
      5'd19:   b = 8'hF1;
      5'd20:   b = 8'hDB;
      5'd21:   b = 8'h40;
      5'd22:   b = 8'hA4;
      5'd23:   b = 8'hA6;
      5'd24:   b = 8'hAF;
      default: b = 8'hAE;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/core/oled_page_framebuffer_flusher_unit.sv -----
// Page-mode display framebuffer with a pull-paced link byte stream.
// Depends on opff_pkg and oled_page_framebuffer_flusher_unit_macros.svh.
//
// Usage:
//   Input words (op, page_index, column_index, pixel_byte) arrive on the
//   in_valid_i/in_ready_o channel. Every word yields exactly one result word
//   on out_valid_o/out_ready_i; a pull word may carry a link byte, other ops
//   report byte_valid 0 together with the present and pending flags.
//   cfg_valid_i/cfg_ready_o writes the contrast level; ready is always high.
//   Control is a ten-step microcode ROM with a step counter; one word runs
//   fetch, decode, its action steps (none for unused ops) and an emit step.
//   Write, init and fail run one action step, unused ops none, and a pull a
//   read step then a send step (framebuffer read is registered). A page fill
//   and a clear step through their bytes, since the
//   single memory write port sweeps one byte per cycle. A pull that sends the
//   last init byte also sweeps the whole store first. The next word is taken
//   in the cycle after the result is loaded, not while a word is in progress.
//   The result sits in an output register; a stalled receiver only holds the
//   sequencer once a second result is ready to be loaded.
//   Reset clears flags, dirty bits and the sequencer; the store itself holds
//   garbage until written, filled or cleared.
module oled_page_framebuffer_flusher_unit import opff_pkg::*; #(
  parameter int PAGE_COUNT   = DEF_PAGE_COUNT,
  parameter int COLUMN_COUNT = DEF_COLUMN_COUNT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [7:0] cfg_contrast_level_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] op_i,
  input  logic [2:0] page_index_i,
  input  logic [6:0] column_index_i,
  input  logic [7:0] pixel_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       byte_valid_o,
  output logic [7:0] link_byte_o,
  output logic       transaction_first_o,
  output logic       transaction_last_o,
  output logic       panel_present_o,
  output logic       pages_pending_o
);

`include "oled_page_framebuffer_flusher_unit_macros.svh"

  localparam int         FB_DEPTH = PAGE_COUNT * COLUMN_COUNT;
  localparam int         FB_AW    = $clog2(FB_DEPTH);
  localparam int         PG_AW    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam logic [7:0] MUX_ARG  = 8'(PAGE_COUNT * 8 - 1);

  // Sequencer
  upc_t  upc_q, upc_d;
  uctl_t uc;
  logic  cond_hit;
  upc_t  disp_tgt;

  // Captured word
  logic [2:0] op_q;
  logic [2:0] page_q;
  logic [6:0] col_q;
  logic [7:0] pix_q;

  logic [7:0] contrast_q;

  // Refresh state
  phase_e              phase_q, phase_d;
  logic [4:0]          init_pos_q, init_pos_d;
  logic [7:0]          bpos_q, bpos_d;
  logic [PG_AW-1:0]    active_q, active_d;
  logic [PAGE_COUNT-1:0] dirty_q, dirty_d;
  logic                present_q, present_d;
  logic [FB_AW-1:0]    cnt_q, cnt_d;
  logic                init_done;

  // Pending result of the current word
  logic       res_valid_q, res_valid_d;
  logic [7:0] res_byte_q, res_byte_d;
  logic       res_first_q, res_first_d;
  logic       res_last_q, res_last_d;

  // Output register
  logic       out_valid_q;
  logic       ob_valid_q;
  logic [7:0] ob_byte_q;
  logic       ob_first_q;
  logic       ob_last_q;
  logic       ob_present_q;
  logic       ob_pending_q;
  logic       out_free;
  logic       out_load;

  // Framebuffer memory
  logic [7:0]       fb_mem [FB_DEPTH];
  logic             mem_we;
  logic [FB_AW-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic             mem_re;
  logic [FB_AW-1:0] mem_raddr;
  logic [7:0]       rdata_q;

  // Address and range helpers
  logic             page_ok;
  logic             col_ok;
  logic [PG_AW-1:0] page_sel;
  logic [FB_AW-1:0] item_addr;
  logic [FB_AW-1:0] fill_addr;
  logic [7:0]       dcol;
  logic [PG_AW-1:0] low_pg;
  logic             in_transfer;

  assign uc          = ucode(upc_q);
  assign in_ready_o  = uc.in_rdy;
  assign cfg_ready_o = 1'b1;

  assign page_ok   = int'(page_q) < PAGE_COUNT;
  assign col_ok    = int'(col_q) < COLUMN_COUNT;
  assign page_sel  = PG_AW'(page_q);
  assign item_addr = FB_AW'(int'(page_q) * COLUMN_COUNT + int'(col_q));
  assign fill_addr = FB_AW'(int'(page_q) * COLUMN_COUNT + int'(cnt_q));
  assign dcol      = (int'(bpos_q) < COLUMN_COUNT) ? bpos_q : 8'd0;
  assign mem_raddr = FB_AW'(int'(active_q) * COLUMN_COUNT + int'(dcol));
  assign in_transfer = phase_q inside {PH_CMDS, PH_HEAD, PH_DATA};

  // Lowest dirty page wins
  always_comb begin
    low_pg = '0;
    for (int p = PAGE_COUNT - 1; p >= 0; p--) begin
      if (dirty_q[p]) low_pg = PG_AW'(p);
    end
  end

  // Multiway jump on the captured op; out-of-range addresses go straight to emit
  always_comb begin
    case (op_e'(op_q))
      OP_WRITE: disp_tgt = (page_ok && col_ok) ? U_WRITE : U_EMIT;
      OP_FILL:  disp_tgt = page_ok ? U_FILL : U_EMIT;
      OP_CLEAR: disp_tgt = U_CLEAR;
      OP_INIT:  disp_tgt = U_INIT;
      OP_PULL:  disp_tgt = U_PULL;
      OP_FAIL:  disp_tgt = U_FAIL;
      default:  disp_tgt = U_EMIT;
    endcase
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign out_load = (uc.act == A_EMIT) && out_free;

  always_comb begin
    case (uc.cond)
      C_ALWAYS:    cond_hit = 1'b1;
      C_ACCEPT:    cond_hit = in_valid_i;
      C_DISPATCH:  cond_hit = 1'b1;
      C_COL_END:   cond_hit = cnt_q == FB_AW'(COLUMN_COUNT - 1);
      C_ALL_END:   cond_hit = cnt_q == FB_AW'(FB_DEPTH - 1);
      C_INIT_DONE: cond_hit = init_done;
      C_OUT_FREE:  cond_hit = out_free;
      default:     cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (uc.cond == C_DISPATCH) begin
      upc_d = disp_tgt;
    end else begin
      upc_d = cond_hit ? uc.tgt_t : uc.tgt_f;
    end
  end

  // Datapath driven by the control word
  always_comb begin
    logic [4:0] ii;
    phase_d     = phase_q;
    init_pos_d  = init_pos_q;
    bpos_d      = bpos_q;
    active_d    = active_q;
    dirty_d     = dirty_q;
    present_d   = present_q;
    cnt_d       = cnt_q;
    res_valid_d = res_valid_q;
    res_byte_d  = res_byte_q;
    res_first_d = res_first_q;
    res_last_d  = res_last_q;
    mem_we      = 1'b0;
    mem_waddr   = item_addr;
    mem_wdata   = pix_q;
    mem_re      = 1'b0;
    init_done   = 1'b0;
    ii          = (int'(init_pos_q) < INIT_LEN) ? init_pos_q : 5'd0;

    case (uc.act)
      A_DECODE: begin
        res_valid_d = 1'b0;
        res_byte_d  = 8'd0;
        res_first_d = 1'b0;
        res_last_d  = 1'b0;
        cnt_d       = '0;
      end
      A_WRITE: begin
        mem_we            = 1'b1;
        dirty_d[page_sel] = 1'b1;
      end
      A_FILL: begin
        mem_we            = 1'b1;
        mem_waddr         = fill_addr;
        cnt_d             = cnt_q + 1'b1;
        dirty_d[page_sel] = 1'b1;
      end
      A_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = 8'd0;
        cnt_d     = cnt_q + 1'b1;
        dirty_d   = '1;
      end
      A_INIT, A_FAIL: begin
        // re-mark a page whose transfer gets cut short
        if (in_transfer) dirty_d[active_q] = 1'b1;
        present_d  = (uc.act == A_INIT);
        phase_d    = (uc.act == A_INIT) ? PH_INIT : PH_IDLE;
        init_pos_d = 5'd0;
        bpos_d     = 8'd0;
      end
      A_READ: begin
        mem_re = 1'b1;
      end
      A_PULL: begin
        cnt_d       = '0;
        res_valid_d = 1'b1;
        res_byte_d  = 8'd0;
        res_first_d = 1'b0;
        res_last_d  = 1'b0;
        // idle with work to do: claim the lowest dirty page
        if (phase_q == PH_IDLE && present_q && (|dirty_q)) begin
          active_d         = low_pg;
          dirty_d[low_pg]  = 1'b0;
          phase_d          = PH_CMDS;
          bpos_d           = 8'd0;
        end
        case (phase_d)
          PH_INIT: begin
            if (bpos_q == 8'd0) begin
              res_byte_d  = CMD_PREFIX;
              res_first_d = 1'b1;
              bpos_d      = 8'd1;
            end else begin
              res_byte_d = init_byte(ii);
              if (ii == INIT_CONTRAST_SLOT) res_byte_d = contrast_q;
              if (ii == INIT_MUX_SLOT) res_byte_d = MUX_ARG;
              res_last_d = 1'b1;
              bpos_d     = 8'd0;
              if (int'(init_pos_q) + 1 >= INIT_LEN) begin
                init_pos_d = 5'd0;
                phase_d    = PH_IDLE;
                init_done  = 1'b1;
              end else begin
                init_pos_d = init_pos_q + 5'd1;
              end
            end
          end
          PH_CMDS: begin
            if (!bpos_d[0]) begin
              res_byte_d  = CMD_PREFIX;
              res_first_d = 1'b1;
            end else begin
              case (bpos_d[2:1])
                2'd0:    res_byte_d = PAGE_ADDR_BASE | 8'(active_d);
                2'd1:    res_byte_d = COL_LOW_CMD;
                default: res_byte_d = COL_HIGH_CMD;
              endcase
              res_last_d = 1'b1;
            end
            if (bpos_d >= 8'd5) begin
              bpos_d  = 8'd0;
              phase_d = PH_HEAD;
            end else begin
              bpos_d = bpos_d + 8'd1;
            end
          end
          PH_HEAD: begin
            res_byte_d  = DATA_PREFIX;
            res_first_d = 1'b1;
            bpos_d      = 8'd0;
            phase_d     = PH_DATA;
          end
          PH_DATA: begin
            res_byte_d = rdata_q;
            if (int'(dcol) + 1 >= COLUMN_COUNT) begin
              res_last_d = 1'b1;
              bpos_d     = 8'd0;
              phase_d    = PH_IDLE;
            end else begin
              bpos_d = dcol + 8'd1;
            end
          end
          default: begin
            res_valid_d = 1'b0;
          end
        endcase
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= U_FETCH;
      contrast_q  <= CONTRAST_RESET;
      phase_q     <= PH_IDLE;
      init_pos_q  <= 5'd0;
      bpos_q      <= 8'd0;
      active_q    <= '0;
      dirty_q     <= '0;
      present_q   <= 1'b0;
      cnt_q       <= '0;
      res_valid_q <= 1'b0;
      res_first_q <= 1'b0;
      res_last_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      phase_q     <= phase_d;
      init_pos_q  <= init_pos_d;
      bpos_q      <= bpos_d;
      active_q    <= active_d;
      dirty_q     <= dirty_d;
      present_q   <= present_d;
      cnt_q       <= cnt_d;
      res_valid_q <= res_valid_d;
      res_first_q <= res_first_d;
      res_last_q  <= res_last_d;
      if (cfg_valid_i) contrast_q <= cfg_contrast_level_i;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: capture the word, hold the result
  always_ff @(posedge clk_i) begin
    res_byte_q <= res_byte_d;
    if (uc.in_rdy && in_valid_i) begin
      op_q   <= op_i;
      page_q <= page_index_i;
      col_q  <= column_index_i;
      pix_q  <= pixel_byte_i;
    end
    if (out_load) begin
      ob_valid_q   <= res_valid_q;
      ob_byte_q    <= res_byte_q;
      ob_first_q   <= res_first_q;
      ob_last_q    <= res_last_q;
      ob_present_q <= present_q;
      ob_pending_q <= |dirty_q;
    end
  end

  // Framebuffer: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) fb_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= fb_mem[mem_raddr];
  end

  assign out_valid_o         = out_valid_q;
  assign byte_valid_o        = ob_valid_q;
  assign link_byte_o         = ob_byte_q;
  assign transaction_first_o = ob_first_q;
  assign transaction_last_o  = ob_last_q;
  assign panel_present_o     = ob_present_q;
  assign pages_pending_o     = ob_pending_q;

  `OPFF_ASSERT(a_accept_decodes, (in_valid_i && in_ready_o) |=> (upc_q == U_DECODE), "accepted word not decoded")
  `OPFF_ASSERT(a_idle_result_clean, (out_valid_o && !byte_valid_o) |-> (link_byte_o == 8'd0 && !transaction_first_o && !transaction_last_o), "result without byte carries data")
  `OPFF_ASSERT(a_fill_in_page, (upc_q == U_FILL) |-> (int'(cnt_q) < COLUMN_COUNT), "fill sweep left its page")
  `OPFF_ASSERT(a_present_drop, $fell(present_q) |-> ($past(upc_q) == U_FAIL), "present flag dropped outside link fail")
  `OPFF_ASSERT_NEVER(a_active_range, in_transfer && (int'(active_q) >= PAGE_COUNT), "page transfer on missing page")

endmodule

// ----- tb/sv/tb_oled_page_framebuffer_flusher_unit.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for oled_page_framebuffer_flusher_unit: predicts every result
// word from a shadow of the framebuffer and the link sequencer, under random idling.
// Depends on opff_pkg and the flusher RTL.
module tb_oled_page_framebuffer_flusher_unit;
  import opff_pkg::*;

  localparam int PAGES          = DEF_PAGE_COUNT;
  localparam int COLS           = DEF_COLUMN_COUNT;
  localparam int CLK_HALF       = 6;
  localparam int STALL_LIMIT    = 6000;
  // The longest words run a full clear sweep; wait that long once more at the end.
  localparam int TAIL_CYCLES    = PAGES * COLS + 16;
  localparam int RANDOM_WORDS   = 100;
  localparam int MAX_REPORTS    = 10;
  localparam int HOLDOFF_CYCLES = 250;

  // Op codes the block must ignore
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  // Link protocol bytes as the panel expects them
  localparam logic [7:0] LEAD_CMD         = 8'h00;
  localparam logic [7:0] LEAD_DATA        = 8'h40;
  localparam logic [7:0] SEL_PAGE         = 8'hB0;
  localparam logic [7:0] SEL_COL_LO       = 8'h00;
  localparam logic [7:0] SEL_COL_HI       = 8'h10;
  localparam logic [7:0] MUX_RATIO        = 8'(PAGES * 8 - 1);
  localparam logic [7:0] CONTRAST_DEFAULT = 8'd159;

  // Panel power-up commands, slot 0 in the low byte
  localparam int POWER_UP_LEN = 25;
  localparam int MUX_POS      = 4;
  localparam int CONTRAST_POS = 17;
  localparam logic [POWER_UP_LEN*8-1:0] POWER_UP_BYTES = {
    8'hAF, 8'hA6, 8'hA4, 8'h40, 8'hDB, 8'hF1, 8'hD9, 8'h9F, 8'h81, 8'h12,
    8'hDA, 8'hC8, 8'hA1, 8'h02, 8'h20, 8'h14, 8'h8D, 8'h40, 8'h00, 8'hD3,
    8'h3F, 8'hA8, 8'h80, 8'hD5, 8'hAE
  };

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] link_byte;
    logic       opens;
    logic       closes;
    logic       present;
    logic       pending;
  } link_word_t;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [7:0] cfg_contrast_level_i;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [2:0] op_i;
  logic [2:0] page_index_i;
  logic [6:0] column_index_i;
  logic [7:0] pixel_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       byte_valid_o;
  logic [7:0] link_byte_o;
  logic       transaction_first_o;
  logic       transaction_last_o;
  logic       panel_present_o;
  logic       pages_pending_o;

  oled_page_framebuffer_flusher_unit #(
    .PAGE_COUNT  (PAGES),
    .COLUMN_COUNT(COLS)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_contrast_level_i(cfg_contrast_level_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .op_i                (op_i),
    .page_index_i        (page_index_i),
    .column_index_i      (column_index_i),
    .pixel_byte_i        (pixel_byte_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .byte_valid_o        (byte_valid_o),
    .link_byte_o         (link_byte_o),
    .transaction_first_o (transaction_first_o),
    .transaction_last_o  (transaction_last_o),
    .panel_present_o     (panel_present_o),
    .pages_pending_o     (pages_pending_o)
  );

  // Shadow of the block: framebuffer, dirty bits and link sequencer position
  logic [7:0]       fb_shadow [PAGES][COLS];
  logic [PAGES-1:0] dirty_shadow;
  logic             present_shadow;
  phase_e           phase_shadow;
  int unsigned      init_slot;
  int unsigned      burst_pos;
  logic [2:0]       active_pg;
  logic [7:0]       contrast_shadow;

  link_word_t  awaited_words [$];
  int unsigned mismatches   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned words_sent   = 0;

  // Sender and receiver pacing
  bit          src_idle_on  = 1'b1;
  bit          sink_idle_on = 1'b1;
  bit          word_held    = 1'b0;
  int unsigned gap_left     = 1;
  int unsigned sink_holdoff = 0;

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Zero the whole store and mark every page dirty (clear op, end of power-up).
  function automatic void wipe_frame();
    int p;
    int c;
    for (p = 0; p < PAGES; p++) begin
      for (c = 0; c < COLS; c++) begin
        fb_shadow[p][c] = 8'h00;
      end
    end
    dirty_shadow = '1;
  endfunction

  function automatic bit page_in_flight();
    return phase_shadow == PH_CMDS || phase_shadow == PH_HEAD || phase_shadow == PH_DATA;
  endfunction

  // Advance the shadow by one accepted word and return the result word it yields.
  function automatic link_word_t predict_link_word(logic [2:0] op, logic [2:0] pg,
                                                   logic [6:0] col, logic [7:0] px);
    link_word_t w;
    int unsigned p;
    w = '0;
    case (op)
      OP_WRITE: begin
        fb_shadow[pg][col] = px;
        dirty_shadow[pg]   = 1'b1;
      end
      OP_FILL: begin
        for (p = 0; p < COLS; p++) fb_shadow[pg][p] = px;
        dirty_shadow[pg] = 1'b1;
      end
      OP_CLEAR: wipe_frame();
      OP_INIT, OP_FAIL: begin
        // An interrupted page transfer has to be sent again later
        if (page_in_flight()) dirty_shadow[active_pg] = 1'b1;
        present_shadow = (op == OP_INIT);
        phase_shadow   = (op == OP_INIT) ? PH_INIT : PH_IDLE;
        init_slot      = 0;
        burst_pos      = 0;
      end
      OP_PULL: begin
        // Idle pull opens a refresh of the lowest dirty page
        if (phase_shadow == PH_IDLE && present_shadow && dirty_shadow != '0) begin
          p = 0;
          while (!dirty_shadow[p]) p++;
          active_pg       = p[2:0];
          dirty_shadow[p] = 1'b0;
          phase_shadow    = PH_CMDS;
          burst_pos       = 0;
        end
        w.byte_valid = 1'b1;
        case (phase_shadow)
          PH_INIT: begin
            if (burst_pos == 0) begin
              w.link_byte = LEAD_CMD;
              w.opens     = 1'b1;
              burst_pos   = 1;
            end else begin
              if (init_slot == MUX_POS) w.link_byte = MUX_RATIO;
              else if (init_slot == CONTRAST_POS) w.link_byte = contrast_shadow;
              else w.link_byte = POWER_UP_BYTES[init_slot*8 +: 8];
              w.closes  = 1'b1;
              burst_pos = 0;
              init_slot++;
              if (init_slot >= POWER_UP_LEN) begin
                init_slot    = 0;
                phase_shadow = PH_IDLE;
                wipe_frame();
              end
            end
          end
          PH_CMDS: begin
            if (!burst_pos[0]) begin
              w.link_byte = LEAD_CMD;
              w.opens     = 1'b1;
            end else begin
              case (burst_pos >> 1)
                0:       w.link_byte = SEL_PAGE | {5'b0, active_pg};
                1:       w.link_byte = SEL_COL_LO;
                default: w.link_byte = SEL_COL_HI;
              endcase
              w.closes = 1'b1;
            end
            burst_pos++;
            if (burst_pos >= 6) begin
              burst_pos    = 0;
              phase_shadow = PH_HEAD;
            end
          end
          PH_HEAD: begin
            w.link_byte  = LEAD_DATA;
            w.opens      = 1'b1;
            burst_pos    = 0;
            phase_shadow = PH_DATA;
          end
          PH_DATA: begin
            w.link_byte = fb_shadow[active_pg][burst_pos];
            if (burst_pos + 1 >= COLS) begin
              w.closes     = 1'b1;
              burst_pos    = 0;
              phase_shadow = PH_IDLE;
            end else begin
              burst_pos++;
            end
          end
          default: w.byte_valid = 1'b0;
        endcase
      end
      default: ;
    endcase
    w.present = present_shadow;
    w.pending = |dirty_shadow;
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("[%0t] %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got)
      note_mismatch($sformatf("%s: expected 0x%02h, got 0x%02h", name, want, got));
  endtask

  // Compare each accepted result word against the oldest prediction.
  always @(posedge clk_i) begin : check_results
    link_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_words.size() == 0) begin
        note_mismatch($sformatf("result word with nothing awaited, link_byte 0x%02h",
                                link_byte_o));
      end else begin
        want = awaited_words.pop_front();
        check_field("byte_valid", 8'(want.byte_valid), 8'(byte_valid_o));
        check_field("link_byte", want.link_byte, link_byte_o);
        check_field("transaction_first", 8'(want.opens), 8'(transaction_first_o));
        check_field("transaction_last", 8'(want.closes), 8'(transaction_last_o));
        check_field("panel_present", 8'(want.present), 8'(panel_present_o));
        check_field("pages_pending", 8'(want.pending), 8'(pages_pending_o));
      end
    end
  end

  // Count cycles in which no channel moves a word; a long quiet stretch means a hang.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("** oled_page_framebuffer_flusher_unit: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall per result word, plus a long hold-off on request
  // ---------------------------------------------------------------------------

  function automatic int unsigned pick_gap(bit enabled);
    return enabled ? $urandom_range(0, 7) : 0;
  endfunction

  initial begin : result_sink
    int unsigned hold;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      hold = pick_gap(sink_idle_on) + sink_holdoff;
      sink_holdoff = 0;
      if (hold != 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offer one word, hold it until taken, then predict its result. The gap to the
  // next word is drawn at the accept edge: zero keeps valid high for back-to-back.
  task automatic issue_word(input logic [2:0] op, input logic [2:0] pg,
                            input logic [6:0] col, input logic [7:0] px);
    if (!word_held) repeat (gap_left) @(posedge clk_i);
    in_valid_i     <= 1'b1;
    op_i           <= op;
    page_index_i   <= pg;
    column_index_i <= col;
    pixel_byte_i   <= px;
    do @(posedge clk_i); while (!in_ready_o);
    awaited_words.push_back(predict_link_word(op, pg, col, px));
    if (op != OP_SPARE_LO && op != OP_SPARE_HI) words_sent++;
    gap_left = pick_gap(src_idle_on);
    if (gap_left == 0) begin
      word_held = 1'b1;
    end else begin
      word_held  = 1'b0;
      in_valid_i <= 1'b0;
    end
  endtask

  // Drop a held valid before the sender goes quiet.
  task automatic idle_input();
    if (word_held) begin
      in_valid_i <= 1'b0;
      word_held  = 1'b0;
      gap_left   = 1;
    end
  endtask

  // Hold the sender until every predicted result word has come back.
  task automatic wait_link_idle();
    idle_input();
    while (awaited_words.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic set_contrast(input logic [7:0] level);
    wait_link_idle();
    cfg_valid_i          <= 1'b1;
    cfg_contrast_level_i <= level;
    do @(posedge clk_i); while (!cfg_ready_o);
    contrast_shadow = level;
    cfg_valid_i <= 1'b0;
  endtask

  // Pull n link bytes; the unused fields carry random bits.
  task automatic pull_run(input int unsigned n);
    repeat (n) issue_word(OP_PULL, 3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)),
                          8'($urandom_range(0, 255)));
  endtask

  // Start the panel and pull the whole power-up sequence out.
  task automatic run_power_up();
    issue_word(OP_INIT, 3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)),
               8'($urandom_range(0, 255)));
    pull_run(2 * POWER_UP_LEN);
  endtask

  task automatic issue_noise_word();
    issue_word(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
               7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Field extremes, every op, idle pulls and interrupted power-up.
  task automatic test_directed_edges();
    issue_word(OP_PULL, 3'd0, 7'd0, 8'h00);        // idle, no panel: nothing to send
    issue_word(OP_FAIL, 3'd7, 7'd127, 8'hFF);      // failure with no link activity
    issue_word(OP_CLEAR, 3'd0, 7'd0, 8'h00);       // defines the whole store
    issue_word(OP_SPARE_LO, 3'd7, 7'd127, 8'hFF);
    issue_word(OP_SPARE_HI, 3'd0, 7'd0, 8'h00);
    issue_word(OP_WRITE, 3'd7, 7'd127, 8'hFF);
    issue_word(OP_WRITE, 3'd0, 7'd0, 8'h00);
    issue_word(OP_WRITE, 3'd5, 7'd64, 8'h5A);
    issue_word(OP_FILL, 3'd3, 7'd127, 8'hA5);
    issue_word(OP_FILL, 3'd0, 7'd0, 8'h00);
    issue_word(OP_FILL, 3'd7, 7'd0, 8'hFF);
    issue_word(OP_PULL, 3'd7, 7'd127, 8'hFF);      // dirty pages but no panel yet
    issue_word(OP_INIT, 3'd0, 7'd0, 8'h00);
    pull_run(4);
    issue_word(OP_INIT, 3'd0, 7'd0, 8'h00);        // restart in the middle of power-up
    pull_run(1);
    issue_word(OP_FAIL, 3'd0, 7'd0, 8'h00);        // failure during power-up
    pull_run(1);
    issue_word(OP_INIT, 3'd2, 7'd33, 8'h3C);
    issue_word(OP_FAIL, 3'd5, 7'd94, 8'hC3);
  endtask

  // Complete power-up at both contrast extremes; each ends with a store wipe.
  task automatic test_power_up();
    set_contrast(8'h00);
    run_power_up();
    set_contrast(8'hFF);
    run_power_up();
  endtask

  // Page bursts with writes into the page on the wire, then failure and restart
  // at several points of a transfer.
  task automatic test_page_refresh();
    issue_word(OP_FILL, 3'd0, 7'd0, 8'($urandom_range(0, 255)));
    issue_word(OP_WRITE, 3'd0, 7'd0, 8'($urandom_range(0, 255)));
    issue_word(OP_WRITE, 3'd0, 7'd127, 8'($urandom_range(0, 255)));
    pull_run(6 + 1 + 10);                          // commands, data lead, ten columns
    issue_word(OP_WRITE, 3'd0, 7'd60, 8'($urandom_range(0, 255)));   // column not yet sent
    issue_word(OP_WRITE, 3'd0, 7'd2, 8'($urandom_range(0, 255)));    // column already sent
    issue_word(OP_WRITE, 3'd5, 7'd9, 8'($urandom_range(0, 255)));
    pull_run(20);
    issue_word(OP_FILL, 3'd0, 7'd0, 8'($urandom_range(0, 255)));     // refill mid-burst
    pull_run(COLS - 30);                           // finish the page
    pull_run(3);                                   // page 0 again, inside its commands
    issue_word(OP_FAIL, 3'd0, 7'd0, 8'h00);
    pull_run(1);
    run_power_up();
    pull_run(6);                                   // stop before the data lead
    issue_word(OP_FAIL, 3'd0, 7'd0, 8'h00);
    run_power_up();
    pull_run(6 + 1 + 20);
    issue_word(OP_INIT, 3'd0, 7'd0, 8'h00);        // restart during the data burst
    pull_run(5);
    issue_word(OP_FAIL, 3'd0, 7'd0, 8'h00);
  endtask

  // Stall the receiver for a long stretch while words keep coming back to back,
  // then pause the sender until everything has drained.
  task automatic test_backpressure();
    run_power_up();
    src_idle_on  = 1'b0;
    sink_holdoff = HOLDOFF_CYCLES;
    repeat (30) begin
      if ($urandom_range(0, 3) == 0) issue_noise_word();
      else pull_run(1);
    end
    wait_link_idle();
    src_idle_on = 1'b1;
  endtask

  // Mostly well-formed refresh and power-up sequences, mixed with noise,
  // interrupts, clears and contrast changes between phases.
  task automatic test_random_traffic();
    int unsigned start;
    int unsigned kind;
    int unsigned n;
    start = words_sent;
    while (words_sent - start < RANDOM_WORDS) begin
      src_idle_on  = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        if (!present_shadow) run_power_up();
        repeat ($urandom_range(0, 3))
          issue_word($urandom_range(0, 1) ? OP_WRITE : OP_FILL, 3'($urandom_range(0, 7)),
                     7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
        n = $urandom_range(8, 140);
        repeat (n) begin
          // Now and then write into the page on the wire
          if ($urandom_range(0, 99) < 8)
            issue_word(OP_WRITE,
                       $urandom_range(0, 1) ? active_pg : 3'($urandom_range(0, 7)),
                       7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
          else
            pull_run(1);
        end
      end else if (kind < 52) begin
        if ($urandom_range(0, 9) < 6) begin
          run_power_up();
        end else begin
          issue_word(OP_INIT, 3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)),
                     8'($urandom_range(0, 255)));
          pull_run($urandom_range(1, 2 * POWER_UP_LEN - 1));
        end
      end else if (kind < 72) begin
        repeat ($urandom_range(1, 8)) issue_noise_word();
      end else if (kind < 82) begin
        issue_word($urandom_range(0, 1) ? OP_FAIL : OP_INIT, 3'($urandom_range(0, 7)),
                   7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)));
      end else if (kind < 86) begin
        issue_word(OP_CLEAR, 3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)),
                   8'($urandom_range(0, 255)));
      end else if (kind < 93) begin
        issue_word(OP_FILL, 3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)),
                   8'($urandom_range(0, 255)));
      end else begin
        set_contrast(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin : run_tests
    rst_ni               = 1'b0;
    cfg_valid_i          = 1'b0;
    cfg_contrast_level_i = 8'h00;
    in_valid_i           = 1'b0;
    op_i                 = OP_WRITE;
    page_index_i         = 3'd0;
    column_index_i       = 7'd0;
    pixel_byte_i         = 8'h00;
    out_ready_i          = 1'b0;

    // Shadow starts from the reset state; the store content is never read before a clear
    wipe_frame();
    dirty_shadow    = '0;
    present_shadow  = 1'b0;
    phase_shadow    = PH_IDLE;
    init_slot       = 0;
    burst_pos       = 0;
    active_pg       = 3'd0;
    contrast_shadow = CONTRAST_DEFAULT;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed_edges();
    test_power_up();
    test_page_refresh();
    test_backpressure();
    test_random_traffic();

    wait_link_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && awaited_words.size() == 0)
      $display("** oled_page_framebuffer_flusher_unit: PASSED **");
    else
      $display("** oled_page_framebuffer_flusher_unit: FAILED **");
    $finish;
  end

endmodule
